[rtl/pfc_pkg.sv]
// Package for the Playfair digraph cipher: shared constants, state codes,
// controller/datapath command and status structs, and letter helper functions.
// No dependencies.
package pfc_pkg;

    localparam int          SIDE    = 5;
    localparam int          CELLS   = SIDE * SIDE;
    localparam int          LETTERS = 26;
    localparam logic [4:0]  LET_X   = 5'd23;
    localparam logic [4:0]  LET_J   = 5'd9;
    localparam logic [4:0]  LET_I   = 5'd8;
    localparam logic [4:0]  LAST_LETTER = 5'd25;
    localparam logic [4:0]  CELL_COUNT  = 5'd25;
    localparam logic [6:0]  ASCII_A     = 7'd65;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_DISPATCH = 10'b00_0000_0010,
        ST_FILL     = 10'b00_0000_0100,
        ST_POSA     = 10'b00_0000_1000,
        ST_POSB     = 10'b00_0001_0000,
        ST_CALC     = 10'b00_0010_0000,
        ST_CELL1    = 10'b00_0100_0000,
        ST_OUT1     = 10'b00_1000_0000,
        ST_CELL2    = 10'b01_0000_0000,
        ST_OUT2     = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic accept;
        logic fill_step;
        logic pos_b_sel;
        logic latch_pos_a;
        logic calc;
        logic cell2_sel;
        logic ld_out1;
        logic ld_out2;
        logic next_pair;
    } cmd_t;

    typedef struct packed {
        logic    is_key;
        logic    item_last;
        logic    pair1;
        logic    pair2;
        logic    fill_done;
        logic    slot_free;
        logic    pend_valid;
        logic [4:0] fill_cnt;
    } sts_t;

    // Returns {valid, letter index}; lower case folds up and J folds to I.
    function automatic logic [5:0] fold_letter(input logic [7:0] c);
        logic [7:0] u;
        logic [4:0] v;
        u = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            u = c - 8'd32;
        end
        v = u[4:0] - 5'd1;
        if (u < 8'h41 || u > 8'h5A) begin
            return 6'd0;
        end
        if (v == LET_J) begin
            v = LET_I;
        end
        return {1'b1, v};
    endfunction

    function automatic coord_t row_of(input cell_t p);
        if (p >= 5'd20) return 3'd4;
        else if (p >= 5'd15) return 3'd3;
        else if (p >= 5'd10) return 3'd2;
        else if (p >= 5'd5) return 3'd1;
        else return 3'd0;
    endfunction

    function automatic coord_t col_of(input cell_t p);
        logic [4:0] r;
        logic [4:0] base;
        r = {2'b00, row_of(p)};
        base = {r[2:0], 2'b00} + r;
        return 3'(p - base);
    endfunction

    // Moves a coordinate one place forward (enc) or back (dec), wrapping at 5.
    function automatic coord_t step_coord(input coord_t x, input logic dec);
        if (dec) return (x == 3'd0) ? 3'd4 : 3'(x - 3'd1);
        else return (x == 3'd4) ? 3'd0 : 3'(x + 3'd1);
    endfunction

    function automatic cell_t cell_of(input coord_t r, input coord_t c);
        return 5'({r, 2'b00}) + 5'(r) + 5'(c);
    endfunction

endpackage

[rtl/pfc_ctrl.sv]
// Controller for the Playfair cipher: one-hot sequencer over key fill and
// digraph lookup steps. Depends on pfc_pkg.
module pfc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  pfc_pkg::sts_t sts,
    output pfc_pkg::cmd_t cmd
);

    pfc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == pfc_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            pfc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = pfc_pkg::ST_DISPATCH;
                end
            end
            pfc_pkg::ST_DISPATCH: begin
                if (sts.is_key) begin
                    state_next = sts.item_last ? pfc_pkg::ST_FILL : pfc_pkg::ST_IDLE;
                end else begin
                    state_next = sts.pair1 ? pfc_pkg::ST_POSA : pfc_pkg::ST_IDLE;
                end
            end
            pfc_pkg::ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (sts.fill_done) begin
                    state_next = pfc_pkg::ST_IDLE;
                end
            end
            pfc_pkg::ST_POSA: begin
                state_next = pfc_pkg::ST_POSB;
            end
            pfc_pkg::ST_POSB: begin
                cmd.pos_b_sel = 1'b1;
                cmd.latch_pos_a = 1'b1;
                state_next = pfc_pkg::ST_CALC;
            end
            pfc_pkg::ST_CALC: begin
                cmd.calc = 1'b1;
                state_next = pfc_pkg::ST_CELL1;
            end
            pfc_pkg::ST_CELL1: begin
                state_next = pfc_pkg::ST_OUT1;
            end
            pfc_pkg::ST_OUT1: begin
                if (sts.slot_free) begin
                    cmd.ld_out1 = 1'b1;
                    state_next = pfc_pkg::ST_CELL2;
                end
            end
            pfc_pkg::ST_CELL2: begin
                cmd.cell2_sel = 1'b1;
                state_next = pfc_pkg::ST_OUT2;
            end
            pfc_pkg::ST_OUT2: begin
                cmd.cell2_sel = 1'b1;
                if (sts.slot_free) begin
                    cmd.ld_out2 = 1'b1;
                    if (sts.pair2) begin
                        cmd.next_pair = 1'b1;
                        state_next = pfc_pkg::ST_POSA;
                    end else begin
                        state_next = pfc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = pfc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/pfc_dp.sv]
// Datapath for the Playfair cipher: key table and letter position memories,
// used-letter flags, digraph rule logic and the output register.
// Depends on pfc_pkg.
module pfc_dp (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic [7:0]    in_char,
    input  logic          in_mode,
    input  logic          in_last,
    input  logic          m_tready,
    output logic          m_tvalid,
    output logic [6:0]    out_char,
    output logic          out_last,
    input  pfc_pkg::cmd_t cmd,
    output pfc_pkg::sts_t sts
);

    // Memories: key table by cell, letter position by letter.
    logic [4:0] kt_mem [pfc_pkg::CELLS];
    logic [4:0] lp_mem [pfc_pkg::LETTERS];
    logic [4:0] kt_rd_reg, lp_rd_reg;

    logic        dir_reg;
    logic [25:0] used_reg, used_next;
    logic [4:0]  fill_reg, fill_next;
    logic        key_done_reg, key_done_next;
    logic [4:0]  k_reg;
    logic [4:0]  pend_reg, pend_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        key_item_reg, last_reg;
    logic        p1_reg, p1_next, p2_reg, p2_next;
    pfc_pkg::letter_t a_reg, a_next, b_reg, b_next, a2_reg, a2_next;
    pfc_pkg::cell_t   pa_reg, c1_reg, c2_reg;
    logic        out_valid_reg;
    logic [6:0]  out_char_reg;
    logic        out_last_reg;

    logic [5:0]  folded;
    logic        lv;
    logic [4:0]  lt;
    logic        we;
    logic [4:0]  w_letter;
    logic [4:0]  fill_base;
    logic [25:0] used_base;
    logic        slot_free;

    assign folded = pfc_pkg::fold_letter(in_char);
    assign lv = folded[5];
    assign lt = folded[4:0];
    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        used_base = used_reg;
        fill_base = fill_reg;
        key_done_next = key_done_reg;
        we = 1'b0;
        w_letter = k_reg;
        pend_next = pend_reg;
        pend_valid_next = pend_valid_reg;
        p1_next = 1'b0;
        p2_next = 1'b0;
        a_next = a_reg;
        b_next = b_reg;
        a2_next = a2_reg;
        if (cmd.accept && !in_mode) begin
            if (key_done_reg) begin
                used_base = '0;
                fill_base = '0;
                key_done_next = 1'b0;
            end
            w_letter = lt;
            we = lv && (fill_base < pfc_pkg::CELL_COUNT) && !used_base[lt];
            if (in_last) begin
                key_done_next = 1'b1;
            end
        end else if (cmd.fill_step) begin
            w_letter = k_reg;
            we = (k_reg != pfc_pkg::LET_J) && (fill_base < pfc_pkg::CELL_COUNT)
                 && !used_base[k_reg];
        end
        if (cmd.accept && in_mode) begin
            if (lv) begin
                if (!pend_valid_reg) begin
                    pend_next = lt;
                    pend_valid_next = 1'b1;
                    if (in_last) begin
                        p1_next = 1'b1;
                        a_next = lt;
                        b_next = pfc_pkg::LET_X;
                        pend_valid_next = 1'b0;
                    end
                end else if (!dir_reg && lt == pend_reg) begin
                    // Doubled letter: pad the pair with X, the repeat waits.
                    p1_next = 1'b1;
                    a_next = pend_reg;
                    b_next = pfc_pkg::LET_X;
                    pend_next = lt;
                    if (in_last) begin
                        p2_next = 1'b1;
                        a2_next = lt;
                        pend_valid_next = 1'b0;
                    end
                end else begin
                    p1_next = 1'b1;
                    a_next = pend_reg;
                    b_next = lt;
                    pend_valid_next = 1'b0;
                end
            end else if (in_last && pend_valid_reg) begin
                p1_next = 1'b1;
                a_next = pend_reg;
                b_next = pfc_pkg::LET_X;
                pend_valid_next = 1'b0;
            end
            if (in_last) begin
                pend_next = '0;
            end
        end
        used_next = used_base;
        fill_next = fill_base;
        if (we) begin
            used_next[w_letter] = 1'b1;
            fill_next = fill_base + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            kt_mem[fill_base] <= w_letter;
            lp_mem[w_letter] <= fill_base;
        end
        lp_rd_reg <= lp_mem[cmd.pos_b_sel ? b_reg : a_reg];
        kt_rd_reg <= kt_mem[cmd.cell2_sel ? c2_reg : c1_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= 1'b0;
            used_reg <= '0;
            fill_reg <= '0;
            key_done_reg <= 1'b0;
            k_reg <= '0;
            pend_reg <= '0;
            pend_valid_reg <= 1'b0;
            key_item_reg <= 1'b0;
            last_reg <= 1'b0;
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                dir_reg <= cfg_wr_data;
            end
            used_reg <= used_next;
            fill_reg <= fill_next;
            key_done_reg <= key_done_next;
            pend_reg <= pend_next;
            pend_valid_reg <= pend_valid_next;
            if (cmd.accept) begin
                key_item_reg <= !in_mode;
                last_reg <= in_last;
                p1_reg <= p1_next;
                p2_reg <= p2_next;
                k_reg <= '0;
            end else if (cmd.next_pair) begin
                p2_reg <= 1'b0;
            end
            if (cmd.fill_step) begin
                k_reg <= k_reg + 5'd1;
            end
            if (cmd.ld_out1 || cmd.ld_out2) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            a_reg <= a_next;
            b_reg <= b_next;
            a2_reg <= a2_next;
        end else if (cmd.next_pair) begin
            a_reg <= a2_reg;
            b_reg <= pfc_pkg::LET_X;
        end
        if (cmd.latch_pos_a) begin
            pa_reg <= lp_rd_reg;
        end
        if (cmd.calc) begin
            automatic pfc_pkg::coord_t ra = pfc_pkg::row_of(pa_reg);
            automatic pfc_pkg::coord_t ca = pfc_pkg::col_of(pa_reg);
            automatic pfc_pkg::coord_t rb = pfc_pkg::row_of(lp_rd_reg);
            automatic pfc_pkg::coord_t cb = pfc_pkg::col_of(lp_rd_reg);
            if (ra == rb) begin
                c1_reg <= pfc_pkg::cell_of(ra, pfc_pkg::step_coord(ca, dir_reg));
                c2_reg <= pfc_pkg::cell_of(rb, pfc_pkg::step_coord(cb, dir_reg));
            end else if (ca == cb) begin
                c1_reg <= pfc_pkg::cell_of(pfc_pkg::step_coord(ra, dir_reg), ca);
                c2_reg <= pfc_pkg::cell_of(pfc_pkg::step_coord(rb, dir_reg), cb);
            end else begin
                c1_reg <= pfc_pkg::cell_of(ra, cb);
                c2_reg <= pfc_pkg::cell_of(rb, ca);
            end
        end
        if (cmd.ld_out1 || cmd.ld_out2) begin
            out_char_reg <= 7'(kt_rd_reg) + pfc_pkg::ASCII_A;
            out_last_reg <= cmd.ld_out2 && last_reg && !p2_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign out_char = out_char_reg;
    assign out_last = out_last_reg;

    assign sts.is_key = key_item_reg;
    assign sts.item_last = last_reg;
    assign sts.pair1 = p1_reg;
    assign sts.pair2 = p2_reg;
    assign sts.fill_done = (k_reg == pfc_pkg::LAST_LETTER);
    assign sts.slot_free = slot_free;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.fill_cnt = fill_reg;

endmodule

[rtl/playfair_digraph_cipher.sv]
// Playfair digraph cipher on a 5x5 key table, stream in and stream out.
// A key item is taken and dispatched; the last key item adds a fill pass over the letters (one letter a step).
// A message item completes up to 2 digraphs, each looked up through the serial position
// and key table memory reads; output stalls hold the lookup.
// Reset (aresetn, synchronous, active low) clears control, flags and fill count;
// the key memories hold whatever they held until a key is written.
module playfair_digraph_cipher (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tuser,   // [0] mode
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tlast
);

    pfc_pkg::cmd_t cmd;
    pfc_pkg::sts_t sts;
    logic [6:0]    out_char;

    pfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_char     (s_tdata),
        .in_mode     (s_tuser),
        .in_last     (s_tlast),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_char    (out_char),
        .out_last    (m_tlast),
        .cmd         (cmd),
        .sts         (sts)
    );

    assign m_tdata = {1'b0, out_char};

    // The key table never grows past its 25 cells.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.fill_cnt <= 5'd25)
        else $error("fill count beyond table size");

    // A message transaction that ends the message leaves no letter waiting.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser && s_tlast) |=> !sts.pend_valid)
        else $error("pending letter left after message end");

    // Results only leave while a message digraph is being worked on.
    a_no_out_on_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ld_out1 || cmd.ld_out2) |-> !sts.is_key)
        else $error("result produced for a key transaction");

endmodule
